@@ rtl/gcm_gtag_pkg.sv @@
// shared types, codes and GF(2^128) helpers for the GHASH tag engine
package gcm_gtag_pkg;

  localparam int BLOCK_W = 128;
  localparam int HALF_W = 64;
  localparam int CNT_W = 61;
  localparam int VB_W = 5;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int BLOCK_BYTES = 16;

  // digit-serial multiplier: one 16-bit digit of the operand per cycle
  localparam int DIGIT_BITS = 16;
  localparam int MUL_STEPS = BLOCK_W / DIGIT_BITS;
  localparam int STEP_W = $clog2(MUL_STEPS);

  localparam int QUEUE_DEPTH_DEF = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_AAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_MASK_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_MASK_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_TAG_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_TAG_LOW = 3'd5;

  // reduction constant, coefficient x^0 in the top bit
  localparam logic [BLOCK_W-1:0] GCM_R = {8'hE1, 120'h0};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HALF_W-1:0] block_high;
    logic [HALF_W-1:0] block_low;
    logic [VB_W-1:0]   valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] tag_high;
    logic [HALF_W-1:0] tag_low;
    logic              tag_matches;
  } out_item_t;

  // queued work: padded block or finish marker
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] data;
    logic [VB_W-1:0]    nbytes;
  } entry_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] hash_key;
    logic [BLOCK_W-1:0] tag_mask;
    logic [BLOCK_W-1:0] expected_tag;
  } cfg_t;

  // v * x^k in GCM bit order, k up to 16
  function automatic logic [BLOCK_W-1:0] mul_xk(input logic [BLOCK_W-1:0] v,
                                                input int unsigned k);
    logic [BLOCK_W-1:0] r;
    r = v >> k;
    for (int p = 0; p < DIGIT_BITS; p++) begin
      if ((p < int'(k)) && v[p]) begin
        r = r ^ (GCM_R >> (int'(k) - 1 - p));
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/gcm_gtag_front.sv @@
// front end: classifies incoming transactions, drops no-ops, pads short blocks
module gcm_gtag_front (
  input  gcm_gtag_pkg::in_item_t in_item,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   q_full,
  output logic                   q_push,
  output gcm_gtag_pkg::entry_t   q_entry
);

  logic [gcm_gtag_pkg::VB_W-1:0]    nbytes;
  logic [gcm_gtag_pkg::BLOCK_W-1:0] keep_mask;
  logic                             keep;

  // saturate the byte count at a full block
  assign nbytes = (in_item.valid_bytes > gcm_gtag_pkg::VB_W'(gcm_gtag_pkg::BLOCK_BYTES)) ?
                  gcm_gtag_pkg::VB_W'(gcm_gtag_pkg::BLOCK_BYTES) : in_item.valid_bytes;

  always_comb begin
    keep_mask = '0;
    for (int b = 0; b < gcm_gtag_pkg::BLOCK_BYTES; b++) begin
      keep_mask[gcm_gtag_pkg::BLOCK_W-1-8*b -: 8] = {8{gcm_gtag_pkg::VB_W'(b) < nbytes}};
    end
  end

  always_comb begin
    unique case (in_item.kind) inside
      gcm_gtag_pkg::KIND_AAD, gcm_gtag_pkg::KIND_TEXT: begin
        keep = (nbytes != '0);
      end
      gcm_gtag_pkg::KIND_FINISH: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_entry.kind = in_item.kind;
  assign q_entry.data = {in_item.block_high, in_item.block_low} & keep_mask;
  assign q_entry.nbytes = nbytes;

  // dropped transactions are still accepted, just never queued
  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full && keep;

endmodule

@@ rtl/gcm_gtag_fifo.sv @@
// short queue between the front end and the multiply back end
module gcm_gtag_fifo #(
  parameter int DEPTH = gcm_gtag_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gcm_gtag_pkg::entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output gcm_gtag_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  gcm_gtag_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> (count == CNT_W'(DEPTH)))
    else $error("queue count moved while full and not popped");

endmodule

@@ rtl/gcm_gtag_back.sv @@
// back end: digit-serial GHASH multiply, byte counters, tag and compare
module gcm_gtag_back (
  input  logic                    clk,
  input  logic                    rst,
  input  gcm_gtag_pkg::cfg_t      cfg,
  input  logic                    q_valid,
  input  gcm_gtag_pkg::entry_t    q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gcm_gtag_pkg::out_item_t out_item
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_MUL = 1'b1;
  localparam int BW = gcm_gtag_pkg::BLOCK_W;
  localparam int DB = gcm_gtag_pkg::DIGIT_BITS;

  logic [0:0]                        state;
  logic [gcm_gtag_pkg::STEP_W-1:0]   step;
  logic                              cur_fin;
  logic [BW-1:0]                     acc;
  logic [BW-1:0]                     opnd;
  logic [gcm_gtag_pkg::CNT_W-1:0]    aad_cnt;
  logic [gcm_gtag_pkg::CNT_W-1:0]    text_cnt;

  logic [BW-1:0] hpow [DB];
  logic [BW-1:0] digit_prod;
  logic [BW-1:0] mul_next;
  logic [BW-1:0] base;
  logic [BW-1:0] start_val;
  logic [BW-1:0] tag;
  logic          last;
  logic          start;
  logic          head_fin;
  logic          load_out;

  // H * x^b for each bit of a digit
  always_comb begin
    for (int b = 0; b < DB; b++) begin
      hpow[b] = gcm_gtag_pkg::mul_xk(cfg.hash_key, b);
    end
  end

  // lowest digit of the operand carries the highest powers of x
  always_comb begin
    digit_prod = '0;
    for (int s = 0; s < DB; s++) begin
      digit_prod = digit_prod ^ ({BW{opnd[s]}} & hpow[DB-1-s]);
    end
  end

  assign mul_next = gcm_gtag_pkg::mul_xk(acc, DB) ^ digit_prod;
  assign last = (state == ST_MUL) && (step == gcm_gtag_pkg::STEP_W'(gcm_gtag_pkg::MUL_STEPS - 1));
  assign load_out = last && cur_fin;

  // accumulator value once this cycle settles; finish clears it
  assign base = (state == ST_MUL) ? (load_out ? '0 : mul_next) : acc;
  assign tag = mul_next ^ cfg.tag_mask;

  assign head_fin = (q_entry.kind == gcm_gtag_pkg::KIND_FINISH);
  assign start = ((state == ST_IDLE) || last) && q_valid &&
                 (!head_fin || (!out_valid && !load_out));
  assign q_pop = start;

  assign start_val = base ^ (head_fin ? {aad_cnt, 3'b000, text_cnt, 3'b000} : q_entry.data);

  always_ff @(posedge clk) begin
    opnd <= start ? start_val : (opnd >> DB);
    if (load_out) begin
      out_item.tag_high <= tag[BW-1 -: gcm_gtag_pkg::HALF_W];
      out_item.tag_low <= tag[gcm_gtag_pkg::HALF_W-1:0];
      out_item.tag_matches <= (tag == cfg.expected_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      cur_fin <= 1'b0;
      acc <= '0;
      aad_cnt <= '0;
      text_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      acc <= start ? '0 : base;
      if (start) begin
        state <= ST_MUL;
        step <= '0;
        cur_fin <= head_fin;
      end else if (last) begin
        state <= ST_IDLE;
      end else if (state == ST_MUL) begin
        step <= step + 1'b1;
      end
      if (start) begin
        case (q_entry.kind)
          gcm_gtag_pkg::KIND_AAD: begin
            aad_cnt <= aad_cnt + gcm_gtag_pkg::CNT_W'(q_entry.nbytes);
          end
          gcm_gtag_pkg::KIND_TEXT: begin
            text_cnt <= text_cnt + gcm_gtag_pkg::CNT_W'(q_entry.nbytes);
          end
          default: begin
            aad_cnt <= '0;
            text_cnt <= '0;
          end
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) load_out |-> !out_valid)
    else $error("result register overwritten");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> ((state == ST_IDLE) || last))
    else $error("queue popped while multiplier busy");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (load_out && !start) |=> (acc == '0 && state == ST_IDLE))
    else $error("accumulator not cleared after finish");

endmodule

@@ rtl/gcm_ghash_tag_engine_unit.sv @@
// top level of the GCM GHASH tag engine: config registers, front end, queue, back end
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+---------------------------------
//  input    | in_valid / in_ready              | in_item  (kind, block, bytes)
//  output   | out_valid / out_ready            | out_item (tag, tag_matches)
//  config   | cfg_wr_en, cfg_index             | cfg_data (64 bits, write only)
//
// each AAD or text block passes one 16-bit digit at a time through the digit-serial GF(2^128)
// multiplier; queued blocks follow back to back, each starting in the last step of the one before
// a finish runs the length block through the multiplier; the tag appears the cycle after its last step
// zero-byte blocks and unused kinds are accepted and discarded
// synchronous reset clears the accumulator, counters, queue and config registers
// the queue lets input transactions land while the multiplier or output stalls
module gcm_ghash_tag_engine_unit #(
  parameter int QUEUE_DEPTH = gcm_gtag_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gcm_gtag_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gcm_gtag_pkg::out_item_t             out_item,
  input  logic                                cfg_wr_en,
  input  logic [gcm_gtag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcm_gtag_pkg::HALF_W-1:0]     cfg_data
);

  gcm_gtag_pkg::cfg_t   cfg;
  gcm_gtag_pkg::entry_t push_entry;
  gcm_gtag_pkg::entry_t head;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gcm_gtag_pkg::REG_HASH_KEY_HIGH: cfg.hash_key[127:64] <= cfg_data;
        gcm_gtag_pkg::REG_HASH_KEY_LOW:  cfg.hash_key[63:0] <= cfg_data;
        gcm_gtag_pkg::REG_TAG_MASK_HIGH: cfg.tag_mask[127:64] <= cfg_data;
        gcm_gtag_pkg::REG_TAG_MASK_LOW:  cfg.tag_mask[63:0] <= cfg_data;
        gcm_gtag_pkg::REG_EXP_TAG_HIGH:  cfg.expected_tag[127:64] <= cfg_data;
        gcm_gtag_pkg::REG_EXP_TAG_LOW:   cfg.expected_tag[63:0] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gcm_gtag_front u_front (
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  gcm_gtag_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  gcm_gtag_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_entry   (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
